[hdl/swtq_pkg.sv]
package swtq_pkg;

    localparam int MAX_RESULTS = 16;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);
    localparam int TASK_W      = 4;
    localparam int TIME_W      = 32;

    typedef enum logic
    {
        OP_ADD  = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        ST_ADDED = 3'd0,
        ST_ZERO  = 3'd1,
        ST_FULL  = 3'd2,
        ST_WOKEN = 3'd3,
        ST_NONE  = 3'd4
    } status_t;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_RUN,
        S_HOLD
    } state_t;

    typedef struct packed
    {
        logic insert;
        logic pop;
    } cell_ctl_t;

endpackage

[hdl/swtq_cell.sv]
module swtq_cell
(
    input  logic                        clk,
    input  swtq_pkg::cell_ctl_t         ctl,
    input  logic                        occ,
    input  logic [swtq_pkg::TASK_W-1:0] new_task,
    input  logic [swtq_pkg::TIME_W-1:0] new_wake,
    input  logic                        prev_keep,
    input  logic [swtq_pkg::TASK_W-1:0] prev_task,
    input  logic [swtq_pkg::TIME_W-1:0] prev_wake,
    input  logic [swtq_pkg::TASK_W-1:0] next_task,
    input  logic [swtq_pkg::TIME_W-1:0] next_wake,
    output logic                        keep,
    output logic [swtq_pkg::TASK_W-1:0] task_q,
    output logic [swtq_pkg::TIME_W-1:0] wake_q
);
    import swtq_pkg::*;

    logic [TASK_W-1:0] task_reg, task_next;
    logic [TIME_W-1:0] wake_reg, wake_next;

    // entry stays put when it wakes no later than the new one (FIFO on ties)
    assign keep   = occ && (wake_reg <= new_wake);
    assign task_q = task_reg;
    assign wake_q = wake_reg;

    always_comb
    begin
        task_next = task_reg;
        wake_next = wake_reg;
        if (ctl.insert && !keep)
        begin
            if (prev_keep)
            begin
                task_next = new_task;
                wake_next = new_wake;
            end
            else
            begin
                task_next = prev_task;
                wake_next = prev_wake;
            end
        end
        else if (ctl.pop)
        begin
            task_next = next_task;
            wake_next = next_wake;
        end
    end

    always_ff @(posedge clk)
    begin
        task_reg <= task_next;
        wake_reg <= wake_next;
    end

endmodule

[hdl/sorted_wakeup_timer_queue_top.sv]
// channel | direction | tdata (lsb up)                     | tuser         | tlast
// s_*     | in        | task_id[3:0] delay now, pad        | op            | -
// m_*     | out       | woken_task[3:0] wake_at, pad       | status[2:0]   | last
//
// Add: taken in idle, inserted across the cell row in the run state, then the result
// waits in the output register. Tick: taken in idle, then for each released entry
// a run step (head compare and shift of the row) and a hold step (output hand-off),
// or one run and hold for a nothing-due result; at most 16 per tick.
// rst_n clears control and count; cell contents are meaningless until written.
// Output stalls hold the row; no new transaction is taken until the last result goes.
module sorted_wakeup_timer_queue_top
#(
    parameter int TASKS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // task_id[3:0], delay[35:4], now[67:36], zero pad
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // woken_task[3:0], wake_at[35:4], zero pad
    output logic [2:0]  m_tuser,   // status
    output logic        m_tlast
);
    import swtq_pkg::*;

    localparam int CW = $clog2(TASKS + 1);

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [TASK_W-1:0] task_reg, task_next;
    logic [TIME_W-1:0] wake_reg, wake_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic              zero_reg, zero_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [RES_W-1:0]  n_reg, n_next;

    status_t           out_status_reg, out_status_next;
    logic [TASK_W-1:0] out_task_reg, out_task_next;
    logic [TIME_W-1:0] out_wake_reg, out_wake_next;
    logic              out_last_reg, out_last_next;

    cell_ctl_t         ctl;
    logic              keep    [TASKS];
    logic [TASK_W-1:0] c_task  [TASKS];
    logic [TIME_W-1:0] c_wake  [TASKS];

    genvar gi;
    generate
        for (gi = 0; gi < TASKS; gi++)
        begin : g_cell
            logic              p_keep;
            logic [TASK_W-1:0] p_task, n_task;
            logic [TIME_W-1:0] p_wake, n_wake;

            if (gi == 0)
            begin : g_head
                assign p_keep = 1'b1;
                assign p_task = c_task[gi];
                assign p_wake = c_wake[gi];
            end
            else
            begin : g_body
                assign p_keep = keep[gi-1];
                assign p_task = c_task[gi-1];
                assign p_wake = c_wake[gi-1];
            end

            if (gi == TASKS - 1)
            begin : g_tail
                assign n_task = c_task[gi];
                assign n_wake = c_wake[gi];
            end
            else
            begin : g_mid
                assign n_task = c_task[gi+1];
                assign n_wake = c_wake[gi+1];
            end

            swtq_cell u_cell
            (
                .clk       (clk),
                .ctl       (ctl),
                .occ       (count_reg > CW'(gi)),
                .new_task  (task_reg),
                .new_wake  (wake_reg),
                .prev_keep (p_keep),
                .prev_task (p_task),
                .prev_wake (p_wake),
                .next_task (n_task),
                .next_wake (n_wake),
                .keep      (keep[gi]),
                .task_q    (c_task[gi]),
                .wake_q    (c_wake[gi])
            );
        end
    endgenerate

    logic due;
    assign due = (count_reg != '0) && (c_wake[0] <= now_reg)
                 && (n_reg != RES_W'(MAX_RESULTS));

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_HOLD);
    assign m_tdata  = {4'b0, out_wake_reg, out_task_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        task_next       = task_reg;
        wake_next       = wake_reg;
        now_next        = now_reg;
        zero_next       = zero_reg;
        count_next      = count_reg;
        n_next          = n_reg;
        out_status_next = out_status_reg;
        out_task_next   = out_task_reg;
        out_wake_next   = out_wake_reg;
        out_last_next   = out_last_reg;
        ctl             = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = op_t'(s_tuser);
                    task_next  = s_tdata[3:0];
                    now_next   = s_tdata[67:36];
                    wake_next  = s_tdata[67:36] + s_tdata[35:4];
                    zero_next  = (s_tdata[35:4] == '0);
                    n_next     = '0;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                state_next = S_HOLD;
                if (op_reg == OP_ADD)
                begin
                    out_task_next = task_reg;
                    out_last_next = 1'b1;
                    if (zero_reg)
                    begin
                        out_status_next = ST_ZERO;
                        out_wake_next   = '0;
                    end
                    else if (count_reg == CW'(TASKS))
                    begin
                        out_status_next = ST_FULL;
                        out_wake_next   = wake_reg;
                    end
                    else
                    begin
                        ctl.insert      = 1'b1;
                        count_next      = count_reg + 1'b1;
                        out_status_next = ST_ADDED;
                        out_wake_next   = wake_reg;
                    end
                end
                else if (due)
                begin
                    ctl.pop         = 1'b1;
                    count_next      = count_reg - 1'b1;
                    n_next          = n_reg + 1'b1;
                    out_status_next = ST_WOKEN;
                    out_task_next   = c_task[0];
                    out_wake_next   = c_wake[0];
                    out_last_next   = (n_reg == RES_W'(MAX_RESULTS - 1))
                                      || (count_reg == CW'(1))
                                      || (c_wake[1] > now_reg);
                end
                else
                begin
                    out_status_next = ST_NONE;
                    out_task_next   = '0;
                    out_wake_next   = '0;
                    out_last_next   = 1'b1;
                end
            end
            S_HOLD:
            begin
                if (m_tready)
                begin
                    state_next = out_last_reg ? S_IDLE : S_RUN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        task_reg       <= task_next;
        wake_reg       <= wake_next;
        now_reg        <= now_next;
        zero_reg       <= zero_next;
        n_reg          <= n_next;
        out_status_reg <= out_status_next;
        out_task_reg   <= out_task_next;
        out_wake_reg   <= out_wake_next;
        out_last_reg   <= out_last_next;
    end

endmodule
